// ----- rtl/core/tpa_pkg.sv -----
// Package: shared types and constants of the triangle primitive assembler.
package tpa_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int MAX_CORNERS    = 6;
    localparam int NUM_SLOTS      = 4;
    localparam int CNT_BITS       = $clog2(MAX_CORNERS + 1);
    localparam int SLOT_BITS      = $clog2(NUM_SLOTS);

    typedef enum logic [1:0] {
        MODE_LIST  = 2'd0,
        MODE_QUAD  = 2'd1,
        MODE_STRIP = 2'd2,
        MODE_FAN   = 2'd3
    } t_mode;

    // Corner source slots: three held vertices and the incoming one.
    typedef enum logic [SLOT_BITS-1:0] {
        SLOT_H0  = 2'd0,
        SLOT_H1  = 2'd1,
        SLOT_H2  = 2'd2,
        SLOT_NEW = 2'd3
    } t_slot;

    typedef struct packed {
        logic [CNT_BITS-1:0]                   count;
        logic [MAX_CORNERS-1:0][SLOT_BITS-1:0] sel;
    } t_batch_ctl;

endpackage

// ----- rtl/core/tpa_if.sv -----
// Interfaces: vertex input channel and triangle corner output channel.
interface tpa_vtx_if #(
    parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic                  start_req;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
    logic [COORD_BITS-1:0] coord_z;

    modport source (output valid, mode, start_req, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, mode, start_req, coord_x, coord_y, coord_z, output ready);
endinterface

interface tpa_tri_if #(
    parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [COORD_BITS-1:0] out_z;
    logic [1:0]            corner;
    logic                  last_corner;

    modport source (output valid, out_x, out_y, out_z, corner, last_corner, input ready);
    modport sink   (input valid, out_x, out_y, out_z, corner, last_corner, output ready);
endinterface

// ----- rtl/core/tpa_assembler.sv -----
// Run state and held vertices; picks the corner pattern for each vertex.
module tpa_assembler #(
    parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  logic [1:0]                          i_mode,
    input  logic                                i_start_req,
    input  logic [3*COORD_BITS-1:0]             i_vtx,
    output tpa_pkg::t_batch_ctl                 o_ctl,
    output logic [tpa_pkg::NUM_SLOTS-1:0][3*COORD_BITS-1:0] o_slots
);
    import tpa_pkg::*;

    localparam int VW = 3 * COORD_BITS;

    t_mode           r_mode, n_mode;
    logic [1:0]      r_pos, n_pos;
    logic            r_par, n_par;
    logic [VW-1:0]   r_held [3];
    logic [VW-1:0]   n_held [3];
    t_mode           eff_mode;
    logic [1:0]      eff_pos;
    logic            eff_par;

    always_comb begin
        eff_mode = i_start_req ? t_mode'(i_mode) : r_mode;
        eff_pos  = i_start_req ? 2'd0 : r_pos;
        eff_par  = i_start_req ? 1'b0 : r_par;
        n_mode   = eff_mode;
        n_pos    = eff_pos;
        n_par    = eff_par;
        n_held   = r_held;
        o_ctl.count = '0;
        o_ctl.sel   = '0;
        unique case (eff_mode)
            MODE_LIST: begin
                if (eff_pos >= 2'd2) begin
                    o_ctl.count = CNT_BITS'(3);
                    o_ctl.sel[0] = SLOT_H0;
                    o_ctl.sel[1] = SLOT_H1;
                    o_ctl.sel[2] = SLOT_NEW;
                    n_pos = 2'd0;
                end else begin
                    n_held[eff_pos] = i_vtx;
                    n_pos = eff_pos + 2'd1;
                end
            end
            MODE_QUAD: begin
                if (eff_pos == 2'd3) begin
                    o_ctl.count = CNT_BITS'(6);
                    o_ctl.sel[0] = SLOT_H0;
                    o_ctl.sel[1] = SLOT_H1;
                    o_ctl.sel[2] = SLOT_H2;
                    o_ctl.sel[3] = SLOT_H2;
                    o_ctl.sel[4] = SLOT_NEW;
                    o_ctl.sel[5] = SLOT_H0;
                    n_pos = 2'd0;
                end else begin
                    n_held[eff_pos] = i_vtx;
                    n_pos = eff_pos + 2'd1;
                end
            end
            MODE_STRIP: begin
                if (eff_pos >= 2'd2) begin
                    o_ctl.count = CNT_BITS'(3);
                    o_ctl.sel[0] = SLOT_H0;
                    o_ctl.sel[1] = eff_par ? SLOT_H1 : SLOT_NEW;
                    o_ctl.sel[2] = eff_par ? SLOT_NEW : SLOT_H1;
                    n_par = ~eff_par;
                    n_held[0] = r_held[1];
                    n_held[1] = i_vtx;
                end else begin
                    n_held[eff_pos] = i_vtx;
                    n_pos = eff_pos + 2'd1;
                end
            end
            MODE_FAN: begin
                if (eff_pos >= 2'd2) begin
                    o_ctl.count = CNT_BITS'(3);
                    o_ctl.sel[0] = SLOT_H0;
                    o_ctl.sel[1] = SLOT_H1;
                    o_ctl.sel[2] = SLOT_NEW;
                    n_held[1] = i_vtx;
                end else begin
                    n_held[eff_pos] = i_vtx;
                    n_pos = eff_pos + 2'd1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_slots[SLOT_H0]  = r_held[0];
        o_slots[SLOT_H1]  = r_held[1];
        o_slots[SLOT_H2]  = r_held[2];
        o_slots[SLOT_NEW] = i_vtx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LIST;
            r_pos  <= 2'd0;
            r_par  <= 1'b0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_par  <= n_par;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_held <= n_held;
        end
    end

endmodule

// ----- rtl/core/tpa_emitter.sv -----
// Corner batch register and output register; sends one corner per cycle while o_tri.ready is high.
module tpa_emitter #(
    parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load_valid,
    output logic                                o_load_ready,
    input  tpa_pkg::t_batch_ctl                 i_ctl,
    input  logic [tpa_pkg::NUM_SLOTS-1:0][3*COORD_BITS-1:0] i_slots,
    tpa_tri_if.source                           o_tri
);
    import tpa_pkg::*;

    localparam int VW = 3 * COORD_BITS;

    logic                              r_busy;
    logic [CNT_BITS-1:0]               r_idx;
    t_batch_ctl                        r_ctl;
    logic [NUM_SLOTS-1:0][VW-1:0]      r_slots;
    logic                              r_ov;
    logic [VW-1:0]                     r_ovtx;
    logic [1:0]                        r_corner;
    logic                              out_free;
    logic                              emit;
    logic                              last;
    logic                              load;
    logic [VW-1:0]                     sel_vtx;
    logic [1:0]                        corner;

    assign out_free     = !r_ov || o_tri.ready;
    assign emit         = r_busy && out_free;
    assign last         = (r_idx == r_ctl.count - CNT_BITS'(1));
    assign o_load_ready = !r_busy || (emit && last);
    assign load         = i_load_valid && o_load_ready;
    assign sel_vtx      = r_slots[r_ctl.sel[r_idx]];
    assign corner       = (r_idx >= CNT_BITS'(3)) ? 2'(r_idx - CNT_BITS'(3)) : 2'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= (i_ctl.count != '0);
                r_idx  <= '0;
            end else if (emit) begin
                if (last) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + CNT_BITS'(1);
            end
            if (out_free) begin
                r_ov <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ctl   <= i_ctl;
            r_slots <= i_slots;
        end
        if (emit) begin
            r_ovtx   <= sel_vtx;
            r_corner <= corner;
        end
    end

    assign o_tri.valid       = r_ov;
    assign o_tri.out_x       = r_ovtx[COORD_BITS-1:0];
    assign o_tri.out_y       = r_ovtx[2*COORD_BITS-1:COORD_BITS];
    assign o_tri.out_z       = r_ovtx[3*COORD_BITS-1:2*COORD_BITS];
    assign o_tri.corner      = r_corner;
    assign o_tri.last_corner = (r_corner == 2'd2);

endmodule

// ----- rtl/core/triangle_primitive_assembler.sv -----
// Top level of the triangle primitive assembler: input register, assembler, emitter.
//
// i_vtx takes one vertex per item: three coordinate words, a mode and a start
// flag that opens a new run (list, quads, strip or fan) and drops held vertices.
// o_tri gives triangle corners, one per item, corners 0 to 2, last_corner on 2.
// Both channels move an item when valid and ready are high at a clock edge.
// After acceptance, a vertex that closes a triangle moves from the input
// register into the batch register, and its first corner then into the
// output register. A vertex that completes nothing loads an empty batch;
// one that emits a triangle loads three corners and a quad's fourth vertex
// six, sent by the single output register one corner per cycle while
// o_tri.ready is high. The next vertex is accepted while the last
// corner of the current batch waits in the output register.
// When o_tri.ready is low the output register holds its corner, the batch and
// input registers fill, and i_vtx.ready drops; nothing is lost.
// Synchronous reset i_rst_n empties all stages and starts a triangle list run.
module triangle_primitive_assembler #(
    parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpa_vtx_if.sink   i_vtx,
    tpa_tri_if.source o_tri
);
    import tpa_pkg::*;

    localparam int VW = 3 * COORD_BITS;

    logic                         r_iv;
    logic [1:0]                   r_mode;
    logic                         r_start;
    logic [VW-1:0]                r_vtx;
    logic                         load_ready;
    logic                         fire;
    logic                         in_take;
    t_batch_ctl                   ctl;
    logic [NUM_SLOTS-1:0][VW-1:0] slots;

    assign fire        = r_iv && load_ready;
    assign i_vtx.ready = !r_iv || load_ready;
    assign in_take     = i_vtx.valid && i_vtx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_vtx.ready) begin
            r_iv <= i_vtx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode  <= i_vtx.mode;
            r_start <= i_vtx.start_req;
            r_vtx   <= {i_vtx.coord_z, i_vtx.coord_y, i_vtx.coord_x};
        end
    end

    tpa_assembler #(.COORD_BITS(COORD_BITS)) u_assembler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_mode      (r_mode),
        .i_start_req (r_start),
        .i_vtx       (r_vtx),
        .o_ctl       (ctl),
        .o_slots     (slots)
    );

    tpa_emitter #(.COORD_BITS(COORD_BITS)) u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_iv),
        .o_load_ready (load_ready),
        .i_ctl        (ctl),
        .i_slots      (slots),
        .o_tri        (o_tri)
    );

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the triangle primitive assembler: random vertex runs checked against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tpa_pkg::*;

    localparam int COORD_W     = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_PRINTS  = 100;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_coord;

    typedef struct packed {
        t_mode  mode;
        logic   start;
        t_coord pos;
    } t_vtx_item;

    typedef struct packed {
        t_coord     pos;
        logic [1:0] corner_no;
        logic       last;
    } t_corner_item;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tpa_vtx_if #(.COORD_BITS(COORD_W)) vtx_ch ();
    tpa_tri_if #(.COORD_BITS(COORD_W)) corner_ch ();

    triangle_primitive_assembler #(.COORD_BITS(COORD_W)) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_vtx   (vtx_ch),
        .o_tri   (corner_ch)
    );

    t_vtx_item    pending_vtx[$];
    t_corner_item exp_corners[$];
    t_vtx_item    cur_vtx;
    int           vtx_pushed   = 0;
    int           vtx_accepted = 0;
    int           err_cnt      = 0;
    int           cycle_cnt    = 0;
    int           src_idle_pct = 25;
    int           snk_idle_pct = 45;

    // predictor state
    t_mode      asm_mode = MODE_LIST;
    logic [1:0] asm_count = '0;
    logic       strip_odd = 1'b0;
    t_coord     held_v[3];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        vtx_ch.valid     = 1'b0;
        vtx_ch.mode      = '0;
        vtx_ch.start_req = 1'b0;
        vtx_ch.coord_x   = '0;
        vtx_ch.coord_y   = '0;
        vtx_ch.coord_z   = '0;
        corner_ch.ready  = 1'b0;
    end

    task automatic report_error(string msg);
        if (err_cnt < MAX_PRINTS)
            $display("ERROR at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic void emit_tri(t_coord a, t_coord b, t_coord c);
        t_coord       tri_v[3];
        t_corner_item ci;
        tri_v = '{a, b, c};
        for (int k = 0; k < 3; k++) begin
            ci.pos       = tri_v[k];
            ci.corner_no = 2'(k);
            ci.last      = (k == 2);
            exp_corners.push_back(ci);
        end
    endfunction

    function automatic void predict_corners(t_vtx_item v);
        if (v.start) begin
            asm_mode  = v.mode;
            asm_count = '0;
            strip_odd = 1'b0;
        end
        case (asm_mode)
            MODE_LIST: begin
                if (asm_count >= 2) begin
                    emit_tri(held_v[0], held_v[1], v.pos);
                    asm_count = '0;
                end else begin
                    held_v[asm_count] = v.pos;
                    asm_count++;
                end
            end
            MODE_QUAD: begin
                if (asm_count >= 3) begin
                    emit_tri(held_v[0], held_v[1], held_v[2]);
                    emit_tri(held_v[2], v.pos, held_v[0]);
                    asm_count = '0;
                end else begin
                    held_v[asm_count] = v.pos;
                    asm_count++;
                end
            end
            MODE_STRIP: begin
                if (asm_count >= 2) begin
                    if (!strip_odd)
                        emit_tri(held_v[0], v.pos, held_v[1]);
                    else
                        emit_tri(held_v[0], held_v[1], v.pos);
                    strip_odd = ~strip_odd;
                    held_v[0] = held_v[1];
                    held_v[1] = v.pos;
                end else begin
                    held_v[asm_count] = v.pos;
                    asm_count++;
                end
            end
            default: begin
                // fan: held_v[0] is the center, held_v[1] the previous vertex
                if (asm_count >= 2) begin
                    emit_tri(held_v[0], held_v[1], v.pos);
                    held_v[1] = v.pos;
                end else begin
                    held_v[asm_count] = v.pos;
                    asm_count++;
                end
            end
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return COORD_W'($urandom());
        endcase
    endfunction

    function automatic t_coord rand_coords();
        t_coord c;
        c.x = rand_word();
        c.y = rand_word();
        c.z = rand_word();
        return c;
    endfunction

    task automatic push_vtx(t_mode m, logic s, t_coord c);
        t_vtx_item v;
        v.mode  = m;
        v.start = s;
        v.pos   = c;
        pending_vtx.push_back(v);
        vtx_pushed++;
    endtask

    // a run opened by a start; the mode field of later items is noise
    task automatic push_run(t_mode m, int n);
        push_vtx(m, 1'b1, rand_coords());
        for (int k = 1; k < n; k++)
            push_vtx(t_mode'($urandom_range(3)), 1'b0, rand_coords());
    endtask

    task automatic push_random(int target);
        int    added;
        int    n;
        t_mode m;
        added = 0;
        while (added < target) begin
            m = t_mode'($urandom_range(3));
            if ($urandom_range(99) < 80) begin
                case (m)
                    MODE_LIST: n = 3 * $urandom_range(1, 3);
                    MODE_QUAD: n = 4 * $urandom_range(1, 2);
                    default:   n = $urandom_range(3, 8);
                endcase
                push_run(m, n);
            end else if ($urandom_range(1)) begin
                n = $urandom_range(1, 3);
                push_run(m, n);
            end else begin
                n = 1;
                push_vtx(m, 1'($urandom_range(1)), rand_coords());
            end
            added += n;
        end
    endtask

    task automatic wait_accepted();
        while (vtx_accepted != vtx_pushed)
            @(posedge clk);
    endtask

    always @(posedge clk) begin : vtx_driver
        logic take;
        if (!rst_n) begin
            vtx_ch.valid <= 1'b0;
        end else begin
            take = vtx_ch.valid && vtx_ch.ready;
            if (take) begin
                predict_corners(cur_vtx);
                vtx_accepted++;
            end
            if (!vtx_ch.valid || take) begin
                if (pending_vtx.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_vtx = pending_vtx.pop_front();
                    vtx_ch.mode      <= cur_vtx.mode;
                    vtx_ch.start_req <= cur_vtx.start;
                    vtx_ch.coord_x   <= cur_vtx.pos.x;
                    vtx_ch.coord_y   <= cur_vtx.pos.y;
                    vtx_ch.coord_z   <= cur_vtx.pos.z;
                    vtx_ch.valid     <= 1'b1;
                end else begin
                    vtx_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : corner_monitor
        t_corner_item want;
        if (!rst_n) begin
            corner_ch.ready <= 1'b0;
        end else begin
            if (corner_ch.valid && corner_ch.ready) begin
                if (exp_corners.size() == 0) begin
                    report_error($sformatf("unexpected corner %0d x=%h y=%h z=%h",
                        corner_ch.corner, corner_ch.out_x, corner_ch.out_y,
                        corner_ch.out_z));
                end else begin
                    want = exp_corners.pop_front();
                    if (corner_ch.out_x !== want.pos.x)
                        report_error($sformatf("out_x got %h want %h",
                            corner_ch.out_x, want.pos.x));
                    if (corner_ch.out_y !== want.pos.y)
                        report_error($sformatf("out_y got %h want %h",
                            corner_ch.out_y, want.pos.y));
                    if (corner_ch.out_z !== want.pos.z)
                        report_error($sformatf("out_z got %h want %h",
                            corner_ch.out_z, want.pos.z));
                    if (corner_ch.corner !== want.corner_no)
                        report_error($sformatf("corner got %0d want %0d",
                            corner_ch.corner, want.corner_no));
                    if (corner_ch.last_corner !== want.last)
                        report_error($sformatf("last_corner got %b want %b",
                            corner_ch.last_corner, want.last));
                end
            end
            corner_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_coord zero_c;
        t_coord ones_c;
        zero_c = '0;
        ones_c = '1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // no start after reset: list run, mode field ignored
        push_vtx(MODE_FAN, 1'b0, zero_c);
        push_vtx(MODE_QUAD, 1'b0, ones_c);
        push_vtx(MODE_STRIP, 1'b0, rand_coords());
        push_run(MODE_QUAD, 4);
        push_run(MODE_STRIP, 5);
        push_run(MODE_FAN, 4);
        // partial list group dropped by a new quad run
        push_run(MODE_LIST, 2);
        push_run(MODE_QUAD, 4);
        // short strip and fan runs emit nothing
        push_run(MODE_STRIP, 2);
        push_run(MODE_FAN, 2);
        push_random(25);
        wait_accepted();

        src_idle_pct <= 45;
        snk_idle_pct <= 25;
        push_random(25);
        wait_accepted();

        src_idle_pct <= 0;
        snk_idle_pct <= 0;
        push_random(25);
        wait_accepted();

        while (exp_corners.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (exp_corners.size() != 0)
            report_error($sformatf("%0d corners never arrived", exp_corners.size()));

        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
